### hw/rtl/sgl_pkg.sv
// Package for the scatter-gather list entry builder: widths, codes and the
// clamp and group size helpers. No dependencies.
`default_nettype none
package sgl_pkg;
    localparam int MAX_BLOCKS_DEF        = 256;
    localparam int ENTRIES_PER_BLOCK_DEF = 5;
    localparam logic [12:0] PAGE_BYTES   = 13'h1000;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_DESC  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_LINK  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_PAGE  = 2'd1;
    localparam logic [1:0] ERR_TABLE = 2'd2;

    // one result record
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  block_index;
        logic [2:0]  entry_slot;
        logic [61:0] group_address;
        logic [22:0] grp_size;
        logic        entry_last;
        logic [63:0] link_pointer;
        logic [8:0]  blocks_used;
        logic [1:0]  error_code;
        logic        run_last;
    } rec_t;

    // clamp payload log2 to 7..12
    function automatic logic [3:0] clamp_lg(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (v < 4'd7) r = 4'd7;
        if (v > 4'd12) r = 4'd12;
        return r;
    endfunction

    // 23-bit group size from chunk start and byte size
    function automatic logic [22:0] grp_size_of(input logic [11:0] addr_lo,
                                                input logic [27:0] size,
                                                input logic [3:0] lg);
        logic [12:0] pmask;
        logic [28:0] aligned;
        logic [28:0] cnt;
        logic [12:0] lastp;
        logic [7:0]  words;
        pmask   = (13'd1 << lg) - 13'd1;
        aligned = {1'b0, size} + {16'd0, 1'b0, addr_lo & pmask[11:0]};
        cnt     = (aligned + {16'd0, pmask}) >> lg;
        lastp   = aligned[12:0] & pmask;
        if (lastp == 13'd0) lastp = pmask + 13'd1;
        words   = lastp[9:2];
        return {words, cnt[14:0]};
    endfunction
endpackage
`default_nettype wire

### hw/rtl/sg_list_entry_builder.sv
// Builds DMA scatter-gather list records from descriptors. An item is taken
// in any cycle in which the builder is idle and the result queue has room; an
// item that yields records (up to four for a descriptor) pushes them one per
// cycle after its transfer while the result queue has room; a push is held
// when an entry fills the last slot of a block and a further record of
// the same item follows, while the table read for the next block is redone.
// Table loads, list restarts and descriptors that only extend the pending
// chunk push no record. Link pointers come from the block address table, a
// synchronous memory read registered ahead of the record it feeds.
// Depends on sgl_pkg and sgl_out_fifo.
`default_nettype none
module sg_list_entry_builder
    import sgl_pkg::*;
#(
    parameter int MAX_BLOCKS        = MAX_BLOCKS_DEF,
    parameter int ENTRIES_PER_BLOCK = ENTRIES_PER_BLOCK_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  table_index,
    input  wire logic [63:0] block_address,
    input  wire logic [63:0] desc_address,
    input  wire logic [12:0] desc_length,
    input  wire logic        desc_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       block_index,
    output logic [2:0]       entry_slot,
    output logic [61:0]      group_address,
    output logic [22:0]      grp_size,
    output logic             entry_last,
    output logic [63:0]      link_pointer,
    output logic [8:0]       blocks_used,
    output logic [1:0]       error_code,
    output logic             run_last
);
    localparam int TW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1) + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_EMIT} state_t;

    state_t      state_reg;
    logic [3:0]  lg_reg;
    logic        pv_reg;
    logic [63:0] pa_reg;
    logic [27:0] ps_reg;
    logic [2:0]  ei_reg;
    logic [CW-1:0] bc_reg;
    logic [63:0] tbl [MAX_BLOCKS];
    logic [63:0] tbl_q_reg;
    logic        tbl_wait_reg;

    // queued work of the current descriptor: up to two entries
    logic        e0_do_reg, e1_do_reg;
    logic [63:0] e0_a_reg, e1_a_reg;
    logic [27:0] e0_s_reg, e1_s_reg;
    logic        link_done_reg;
    logic        last_pending_reg;

    logic  fifo_room, push;
    rec_t  push_rec, pop_rec;
    logic  pop_valid;
    logic  adv_slot, bc_step;

    assign in_stall = (state_reg != ST_IDLE) || !fifo_room;
    wire   acc = in_valid && !in_stall;

    // merge decision
    logic [13:0] pg_sum;
    logic [63:0] pend_end;
    logic [28:0] merged;
    logic [28:0] max_chunk;
    logic        page_err, can_merge;
    always_comb
    begin
        pg_sum    = {1'b0, desc_length} + {2'b0, desc_address[11:0]};
        page_err  = pg_sum > {1'b0, PAGE_BYTES};
        pend_end  = pa_reg + {36'd0, ps_reg};
        merged    = {1'b0, ps_reg} + {16'd0, desc_length};
        max_chunk = 29'h8000 << clamp_lg(lg_reg);
        can_merge = pv_reg && desc_address == pend_end && pend_end > pa_reg
                    && merged <= max_chunk;
    end

    // next record builder: table error, link or entry (entry uses e0 if pending else e1)
    logic        cur_is0;
    logic [63:0] cur_a;
    logic [27:0] cur_s;
    logic        cur_last, need_link, ovf, more;
    always_comb
    begin
        cur_is0   = e0_do_reg;
        cur_a     = cur_is0 ? e0_a_reg : e1_a_reg;
        cur_s     = cur_is0 ? e0_s_reg : e1_s_reg;
        cur_last  = !cur_is0 && last_pending_reg;
        ovf       = bc_reg >= CW'(MAX_BLOCKS);
        need_link = !ovf && ei_reg == 3'd0 && bc_reg != '0 && !link_done_reg;
        more      = need_link || (cur_is0 && e1_do_reg);
        push_rec  = '0;
        push_rec.block_index = bc_reg[7:0];
        if (ovf)
        begin
            push_rec.kind       = KIND_ERROR;
            push_rec.error_code = ERR_TABLE;
        end
        else if (need_link)
        begin
            push_rec.kind         = KIND_LINK;
            push_rec.block_index  = 8'(bc_reg - CW'(1));
            push_rec.link_pointer = {1'b0, tbl_q_reg[63:1]} | 64'd1;
        end
        else
        begin
            push_rec.kind          = KIND_ENTRY;
            push_rec.entry_slot    = ei_reg;
            push_rec.group_address = cur_a[63:2];
            push_rec.grp_size      = grp_size_of(cur_a[11:0], cur_s, clamp_lg(lg_reg));
            push_rec.entry_last    = cur_last;
            push_rec.blocks_used   = cur_last ? 9'(bc_reg + CW'(1)) : 9'd0;
        end
        push_rec.run_last = !more;
    end

    // hold the push after a block change so the table read catches up
    assign push = (state_reg == ST_EMIT) && fifo_room && !tbl_wait_reg;

    // slot advance on an entry that does not end the list
    assign adv_slot = push && (e0_do_reg || e1_do_reg) && !need_link && !ovf && !cur_last;
    assign bc_step  = adv_slot && ei_reg == 3'(ENTRIES_PER_BLOCK - 1);

    // table memory: write on load, read the slot the next link needs
    always_ff @(posedge clk)
    begin
        if (acc && func == FUNC_LOAD && {24'd0, table_index} < 32'(MAX_BLOCKS))
            tbl[TW'(table_index)] <= block_address;
        tbl_q_reg <= tbl[bc_reg[TW-1:0]];
    end

    // control and chunk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lg_reg    <= 4'd8;
            pv_reg    <= 1'b0;
            pa_reg    <= '0;
            ps_reg    <= '0;
            ei_reg    <= '0;
            bc_reg    <= '0;
            e0_do_reg <= 1'b0;
            e1_do_reg <= 1'b0;
            e0_a_reg  <= '0;
            e1_a_reg  <= '0;
            e0_s_reg  <= '0;
            e1_s_reg  <= '0;
            link_done_reg    <= 1'b0;
            last_pending_reg <= 1'b0;
            tbl_wait_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we) lg_reg <= cfg_wdata;
            tbl_wait_reg <= bc_step;
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc && func == FUNC_CLEAR)
                    begin
                        pv_reg <= 1'b0;
                        pa_reg <= '0;
                        ps_reg <= '0;
                        ei_reg <= '0;
                        bc_reg <= '0;
                    end
                    else if (acc && func == FUNC_DESC)
                    begin
                        link_done_reg <= 1'b0;
                        if (page_err)
                        begin
                            e0_do_reg <= 1'b0;
                            e1_do_reg <= 1'b0;
                            last_pending_reg <= 1'b0;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            e0_do_reg <= pv_reg && !can_merge;
                            e0_a_reg  <= pa_reg;
                            e0_s_reg  <= ps_reg;
                            e1_a_reg  <= can_merge ? pa_reg : desc_address;
                            e1_s_reg  <= can_merge ? merged[27:0] : 28'(desc_length);
                            e1_do_reg <= desc_last;
                            last_pending_reg <= desc_last;
                            if (desc_last)
                            begin
                                pv_reg <= 1'b0;
                                pa_reg <= '0;
                                ps_reg <= '0;
                            end
                            else
                            begin
                                pv_reg <= 1'b1;
                                pa_reg <= can_merge ? pa_reg : desc_address;
                                ps_reg <= can_merge ? merged[27:0] : 28'(desc_length);
                            end
                            if ((pv_reg && !can_merge) || desc_last)
                                state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (push)
                    begin
                        if (!e0_do_reg && !e1_do_reg)
                            state_reg <= ST_IDLE;      // page error record
                        else if (need_link)
                            link_done_reg <= 1'b1;
                        else
                        begin
                            link_done_reg <= 1'b0;
                            if (cur_last)
                            begin
                                ei_reg <= '0;
                                bc_reg <= '0;
                            end
                            else if (adv_slot)
                            begin
                                if (bc_step)
                                begin
                                    ei_reg <= '0;
                                    bc_reg <= bc_reg + CW'(1);
                                end
                                else
                                    ei_reg <= ei_reg + 3'd1;
                            end
                            if (cur_is0)
                            begin
                                e0_do_reg <= 1'b0;
                                if (!e1_do_reg) state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                e1_do_reg <= 1'b0;
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // page error record overrides the entry builder
    rec_t fifo_in;
    always_comb
    begin
        fifo_in = push_rec;
        if (!e0_do_reg && !e1_do_reg)
        begin
            fifo_in             = '0;
            fifo_in.kind        = KIND_ERROR;
            fifo_in.block_index = bc_reg[7:0];
            fifo_in.error_code  = ERR_PAGE;
            fifo_in.run_last    = 1'b1;
        end
    end

    sgl_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (fifo_in),
        .room      (fifo_room),
        .pop_valid (pop_valid),
        .pop_rec   (pop_rec),
        .pop       (pop_valid && !out_stall)
    );

    assign out_valid     = pop_valid;
    assign kind          = pop_rec.kind;
    assign block_index   = pop_rec.block_index;
    assign entry_slot    = pop_rec.entry_slot;
    assign group_address = pop_rec.group_address;
    assign grp_size      = pop_rec.grp_size;
    assign entry_last    = pop_rec.entry_last;
    assign link_pointer  = pop_rec.link_pointer;
    assign blocks_used   = pop_rec.blocks_used;
    assign error_code    = pop_rec.error_code;
    assign run_last      = pop_rec.run_last;
endmodule
`default_nettype wire

### hw/rtl/sgl_out_fifo.sv
// Small result queue between the builder and the output channel.
// Depends on sgl_pkg.
`default_nettype none
module sgl_out_fifo
    import sgl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire rec_t push_rec,
    output logic      room,
    output logic      pop_valid,
    output rec_t      pop_rec,
    input  wire logic pop
);
    localparam int DEPTH = 8;
    rec_t           mem [DEPTH];
    logic [2:0]     wr_reg, rd_reg;
    logic [3:0]     cnt_reg;

    // keep room for a whole burst of four records
    assign room      = cnt_reg <= 4'd4;
    assign pop_valid = cnt_reg != 4'd0;
    assign pop_rec   = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 3'd1;
            if (pop)  rd_reg <= rd_reg + 3'd1;
            cnt_reg <= cnt_reg + {3'd0, push} - {3'd0, pop};
        end
    end
endmodule
`default_nettype wire
